@@ design/sss_pkg.sv @@
// Sleep stage sequencer package: field widths, stage, mode and register codes,
// register reset values, and the request and response payload types.
// No dependencies.
package sss_pkg;

   // Field and state widths
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned STAGE_W    = 2;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned TIMER_W    = 16;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned CYCLE_W    = 16;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned THR_W      = 17;
   localparam int unsigned PROD_W     = LEN_W + CYCLE_W;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 17;

   // Input modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WAKE  = 2'd2;

   // Sleep stages
   localparam logic [STAGE_W-1:0] ST_AWAKE = 2'd0;
   localparam logic [STAGE_W-1:0] ST_NREM  = 2'd1;
   localparam logic [STAGE_W-1:0] ST_REM   = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NREM_BASE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NREM_MIN    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NREM_SHRINK = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REM_BASE    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REM_GROW    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_REM_MAX     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_THETA_INC   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_PGO_THR     = 3'd7;

   // Register reset values
   localparam logic [LEN_W-1:0]   NREM_BASE_RST   = 16'd900;
   localparam logic [LEN_W-1:0]   NREM_MIN_RST    = 16'd300;
   localparam logic [LEN_W-1:0]   NREM_SHRINK_RST = 16'd100;
   localparam logic [LEN_W-1:0]   REM_BASE_RST    = 16'd100;
   localparam logic [LEN_W-1:0]   REM_GROW_RST    = 16'd50;
   localparam logic [LEN_W-1:0]   REM_MAX_RST     = 16'd400;
   localparam logic [PHASE_W-1:0] THETA_INC_RST   = 16'd6554;
   localparam logic [THR_W-1:0]   PGO_THR_RST     = 17'd19661;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SAMPLE_W-1:0] random_sample;
   } sss_req_type;

   typedef struct packed {
      logic [STAGE_W-1:0] stage;
      logic [PHASE_W-1:0] theta_phase;
      logic               pgo_active;
      logic [CYCLE_W-1:0] cycles_done;
      logic [TIMER_W-1:0] ticks_in_stage;
      logic [TOTAL_W-1:0] sleep_ticks_total;
   } sss_rsp_type;

endpackage

@@ design/sleep_stage_sequencer.sv @@
// Sleep stage sequencer top level: stage state, length computation, config
// registers and the registered response stage.
// Depends on sss_pkg.
//
// Usage:
//   Request channel (req_valid / req_ready / req_data) carries one command per
//   transfer: a tick, enter sleep, or wake up, plus a random sample used for
//   the PGO decision on REM ticks.
//   Response channel (rsp_valid / rsp_ready / rsp_data) returns exactly one
//   item per request: the stage, phase, PGO flag and counters after the
//   command has taken effect.
//   The response is valid in the cycle after the request transfer, and the
//   throughput is one request per cycle while the receiver takes each item;
//   the stage update, including the 16x16 length products taken on NREM entry,
//   fits in the single pass from the state registers back into them.
//   When the receiver stalls, the response register holds its item and
//   req_ready stays high only if that item is taken in the same cycle.
//   The csr_ port writes one register per cycle with no handshake; write it
//   only while no response is outstanding. Stage lengths are latched on NREM
//   entry, so a write to a length register takes effect at the next entry.
//   Synchronous reset returns the stage to awake, clears all counters and
//   loads the default register values; no response is pending after reset.
module sleep_stage_sequencer
   import sss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sss_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sss_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Config registers
   logic [LEN_W-1:0]   nrem_base_ff, nrem_min_ff, nrem_shrink_ff;
   logic [LEN_W-1:0]   rem_base_ff, rem_grow_ff, rem_max_ff;
   logic [PHASE_W-1:0] theta_inc_ff;
   logic [THR_W-1:0]   pgo_thr_ff;

   // Sequencer state
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [CYCLE_W-1:0] cycle_ff, cycle_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               pgo_ff, pgo_in;
   logic [LEN_W-1:0]   nrem_len_ff, nrem_len_in;
   logic [LEN_W-1:0]   rem_len_ff, rem_len_in;

   // Response stage
   logic               rsp_valid_ff, rsp_valid_in;
   sss_rsp_type        rsp_data_ff;

   logic               req_fire;
   logic [TIMER_W-1:0] timer_inc;
   logic [CYCLE_W-1:0] cycle_inc;
   logic [TOTAL_W-1:0] total_inc;
   logic [PHASE_W-1:0] phase_add;
   logic               pgo_hit;
   logic [CYCLE_W-1:0] len_cycle;
   logic [PROD_W-1:0]  shrink_prod, grow_prod;
   logic [LEN_W-1:0]   nrem_raw, nrem_new, rem_new;
   logic [PROD_W:0]    rem_sum;
   logic               enter_nrem;

   // Handshake: the response register frees up when its item is taken
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // Saturating increments and REM tick arithmetic
   assign timer_inc = (timer_ff == '1) ? timer_ff : timer_ff + TIMER_W'(1);
   assign cycle_inc = (cycle_ff == '1) ? cycle_ff : cycle_ff + CYCLE_W'(1);
   assign total_inc = (total_ff == '1) ? total_ff : total_ff + TOTAL_W'(1);
   assign phase_add = phase_ff + theta_inc_ff;
   assign pgo_hit   = {1'b0, req_data.random_sample} < pgo_thr_ff;

   // Stage lengths for the cycle count that NREM is entered with
   assign len_cycle   = (req_data.mode == MODE_SLEEP) ? '0 : cycle_inc;
   assign shrink_prod = PROD_W'(nrem_shrink_ff) * PROD_W'(len_cycle);
   assign grow_prod   = PROD_W'(rem_grow_ff) * PROD_W'(len_cycle);
   assign nrem_raw    = ({{CYCLE_W{1'b0}}, nrem_base_ff} > shrink_prod)
                        ? nrem_base_ff - shrink_prod[LEN_W-1:0] : nrem_min_ff;
   assign nrem_new    = (nrem_raw < nrem_min_ff) ? nrem_min_ff : nrem_raw;
   assign rem_sum     = {{(CYCLE_W+1){1'b0}}, rem_base_ff} + {1'b0, grow_prod};
   assign rem_new     = (rem_sum > {{(CYCLE_W+1){1'b0}}, rem_max_ff})
                        ? rem_max_ff : rem_sum[LEN_W-1:0];

   // Next state for the accepted command
   always_comb begin
      stage_in    = stage_ff;
      timer_in    = timer_ff;
      cycle_in    = cycle_ff;
      total_in    = total_ff;
      phase_in    = phase_ff;
      pgo_in      = pgo_ff;
      enter_nrem  = 1'b0;
      case (req_data.mode)
         MODE_TICK: begin
            if (stage_ff != ST_AWAKE) begin
               timer_in = timer_inc;
               total_in = total_inc;
            end
            case (stage_ff)
               ST_NREM: begin
                  if (timer_inc >= nrem_len_ff) begin
                     stage_in = ST_REM;
                     timer_in = '0;
                     phase_in = '0;
                     pgo_in   = 1'b0;
                  end
               end
               ST_REM: begin
                  phase_in = phase_add;
                  pgo_in   = pgo_hit;
                  if (timer_inc >= rem_len_ff) begin
                     cycle_in   = cycle_inc;
                     enter_nrem = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         MODE_SLEEP: begin
            if (stage_ff == ST_AWAKE) begin
               cycle_in   = '0;
               total_in   = '0;
               enter_nrem = 1'b1;
            end
         end
         MODE_WAKE: begin
            stage_in = ST_AWAKE;
            timer_in = '0;
            phase_in = '0;
            pgo_in   = 1'b0;
         end
         default: begin
         end
      endcase
      // NREM entry clears the stage variables and latches both lengths
      if (enter_nrem) begin
         stage_in = ST_NREM;
         timer_in = '0;
         phase_in = '0;
         pgo_in   = 1'b0;
      end
   end

   assign nrem_len_in = enter_nrem ? nrem_new : nrem_len_ff;
   assign rem_len_in  = enter_nrem ? rem_new : rem_len_ff;

   // Config register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         nrem_base_ff   <= NREM_BASE_RST;
         nrem_min_ff    <= NREM_MIN_RST;
         nrem_shrink_ff <= NREM_SHRINK_RST;
         rem_base_ff    <= REM_BASE_RST;
         rem_grow_ff    <= REM_GROW_RST;
         rem_max_ff     <= REM_MAX_RST;
         theta_inc_ff   <= THETA_INC_RST;
         pgo_thr_ff     <= PGO_THR_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NREM_BASE:   nrem_base_ff   <= csr_wdata[LEN_W-1:0];
            CSR_NREM_MIN:    nrem_min_ff    <= csr_wdata[LEN_W-1:0];
            CSR_NREM_SHRINK: nrem_shrink_ff <= csr_wdata[LEN_W-1:0];
            CSR_REM_BASE:    rem_base_ff    <= csr_wdata[LEN_W-1:0];
            CSR_REM_GROW:    rem_grow_ff    <= csr_wdata[LEN_W-1:0];
            CSR_REM_MAX:     rem_max_ff     <= csr_wdata[LEN_W-1:0];
            CSR_THETA_INC:   theta_inc_ff   <= csr_wdata[PHASE_W-1:0];
            CSR_PGO_THR:     pgo_thr_ff     <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Advance the state on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= ST_AWAKE;
         timer_ff    <= '0;
         cycle_ff    <= '0;
         total_ff    <= '0;
         phase_ff    <= '0;
         pgo_ff      <= 1'b0;
         nrem_len_ff <= '0;
         rem_len_ff  <= '0;
      end else if (req_fire) begin
         stage_ff    <= stage_in;
         timer_ff    <= timer_in;
         cycle_ff    <= cycle_in;
         total_ff    <= total_in;
         phase_ff    <= phase_in;
         pgo_ff      <= pgo_in;
         nrem_len_ff <= nrem_len_in;
         rem_len_ff  <= rem_len_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response with the post-command state; hold it while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff.stage             <= stage_in;
         rsp_data_ff.theta_phase       <= phase_in;
         rsp_data_ff.pgo_active        <= pgo_in;
         rsp_data_ff.cycles_done       <= cycle_in;
         rsp_data_ff.ticks_in_stage    <= timer_in;
         rsp_data_ff.sleep_ticks_total <= total_in;
      end
   end

   // Awake carries no stage timer, phase or PGO flag
   assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_AWAKE |-> timer_ff == '0 && phase_ff == '0 && !pgo_ff)
      else $error("awake stage with nonzero stage variables");

   // The phase only moves and PGO only fires in REM
   assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_NREM |-> phase_ff == '0 && !pgo_ff)
      else $error("NREM stage with nonzero phase or PGO flag");

   // A wake command always lands in awake
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.mode == MODE_WAKE |=> stage_ff == ST_AWAKE)
      else $error("wake command did not return to awake");

   // Every transfer leaves a response pending
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("request transfer produced no response");

   // The cycle count only drops on sleep entry
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_data.mode == MODE_SLEEP) |=> cycle_ff >= $past(cycle_ff))
      else $error("cycle count decreased without sleep entry");

endmodule

@@ tb/tb_sleep_stage_sequencer.sv @@
// Self-checking testbench for sleep_stage_sequencer: drives commands and register settings,
// predicts every report in a scoreboard class and compares it field by field.
// Depends on sss_pkg and the sleep_stage_sequencer RTL.
`timescale 1ns / 100ps

module tb_sleep_stage_sequencer;
   import sss_pkg::*;

   // Mode code with no meaning; the block must leave its state alone
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 60;

   // Scoreboard: tracks the sequencer state and holds the reports still due
   class stage_tracker;
      logic [LEN_W-1:0]   nrem_base, nrem_min, nrem_shrink;
      logic [LEN_W-1:0]   rem_base, rem_grow, rem_max;
      logic [PHASE_W-1:0] theta_inc;
      logic [THR_W-1:0]   pgo_thr;
      logic [STAGE_W-1:0] stage;
      logic [TIMER_W-1:0] timer;
      logic [CYCLE_W-1:0] cycles;
      logic [TOTAL_W-1:0] total;
      logic [PHASE_W-1:0] phase;
      logic               pgo;
      logic [LEN_W-1:0]   nrem_len, rem_len;
      sss_rsp_type        expected_reports[$];
      int                 errors;

      function new();
         nrem_base   = NREM_BASE_RST;
         nrem_min    = NREM_MIN_RST;
         nrem_shrink = NREM_SHRINK_RST;
         rem_base    = REM_BASE_RST;
         rem_grow    = REM_GROW_RST;
         rem_max     = REM_MAX_RST;
         theta_inc   = THETA_INC_RST;
         pgo_thr     = PGO_THR_RST;
         stage       = ST_AWAKE;
         timer       = '0;
         cycles      = '0;
         total       = '0;
         phase       = '0;
         pgo         = 1'b0;
         nrem_len    = '0;
         rem_len     = '0;
         errors      = 0;
      endfunction

      function bit is_asleep();
         return stage != ST_AWAKE;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_NREM_BASE:   nrem_base   = value[LEN_W-1:0];
            CSR_NREM_MIN:    nrem_min    = value[LEN_W-1:0];
            CSR_NREM_SHRINK: nrem_shrink = value[LEN_W-1:0];
            CSR_REM_BASE:    rem_base    = value[LEN_W-1:0];
            CSR_REM_GROW:    rem_grow    = value[LEN_W-1:0];
            CSR_REM_MAX:     rem_max     = value[LEN_W-1:0];
            CSR_THETA_INC:   theta_inc   = value[PHASE_W-1:0];
            CSR_PGO_THR:     pgo_thr     = value[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void clear_stage_state();
         timer = '0;
         phase = '0;
         pgo   = 1'b0;
      endfunction

      // Latch both stage lengths for the coming NREM-REM cycle
      function void enter_nrem();
         logic [PROD_W-1:0] shrink;
         logic [PROD_W-1:0] growth;
         logic [PROD_W:0]   rem_sum;
         logic [LEN_W-1:0]  len;
         shrink = PROD_W'(nrem_shrink) * PROD_W'(cycles);
         growth = PROD_W'(rem_grow) * PROD_W'(cycles);
         if (PROD_W'(nrem_base) > shrink) len = nrem_base - shrink[LEN_W-1:0];
         else len = nrem_min;
         if (len < nrem_min) len = nrem_min;
         nrem_len = len;
         // Sum is one bit wider than the product so it cannot wrap
         rem_sum = (PROD_W+1)'(rem_base) + (PROD_W+1)'(growth);
         if (rem_sum > (PROD_W+1)'(rem_max)) rem_len = rem_max;
         else rem_len = rem_sum[LEN_W-1:0];
         stage = ST_NREM;
         clear_stage_state();
      endfunction

      function void take_tick(logic [SAMPLE_W-1:0] sample);
         if (stage == ST_AWAKE) return;
         if (timer != '1) timer++;
         if (total != '1) total++;
         if (stage == ST_NREM) begin
            if (timer >= nrem_len) begin
               stage = ST_REM;
               clear_stage_state();
            end
         end else if (stage == ST_REM) begin
            phase = phase + theta_inc;
            pgo   = ({1'b0, sample} < pgo_thr);
            // End of REM closes a cycle and drops the flag just computed
            if (timer >= rem_len) begin
               if (cycles != '1) cycles++;
               enter_nrem();
            end
         end
      endfunction

      // Apply one accepted command and queue the report it must produce
      function void note_command(sss_req_type cmd);
         sss_rsp_type rep;
         case (cmd.mode)
            MODE_TICK: take_tick(cmd.random_sample);
            MODE_SLEEP: begin
               if (stage == ST_AWAKE) begin
                  cycles = '0;
                  total  = '0;
                  enter_nrem();
               end
            end
            MODE_WAKE: begin
               stage = ST_AWAKE;
               clear_stage_state();
            end
            default: ;
         endcase
         rep.stage             = stage;
         rep.theta_phase       = phase;
         rep.pgo_active        = pgo;
         rep.cycles_done       = cycles;
         rep.ticks_in_stage    = timer;
         rep.sleep_ticks_total = total;
         expected_reports.push_back(rep);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_report(sss_rsp_type got);
         sss_rsp_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: report with none due: expected nothing, actual %h", $time, got);
            return;
         end
         want = expected_reports.pop_front();
         check_field("stage", want.stage, got.stage);
         check_field("theta_phase", want.theta_phase, got.theta_phase);
         check_field("pgo_active", want.pgo_active, got.pgo_active);
         check_field("cycles_done", want.cycles_done, got.cycles_done);
         check_field("ticks_in_stage", want.ticks_in_stage, got.ticks_in_stage);
         check_field("sleep_ticks_total", want.sleep_ticks_total, got.sleep_ticks_total);
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sss_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sss_rsp_type           rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // calm turns off random idling on both sides
   logic calm      = 1'b0;
   int   hold_asks = 0;
   int   hold_done = 0;
   int   hold_left = 0;

   stage_tracker tracker;

   sleep_stage_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 7);
      end
   end

   // Check every report transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_report(rsp_data);
   end

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      if ($urandom_range(15) == 0) return $urandom_range(1) ? '1 : '0;
      return SAMPLE_W'($urandom_range(65535));
   endfunction

   // Random 16-bit register value; bit 16 is random and must be ignored
   function automatic logic [CSR_DATA_W-1:0] rand_len(int unsigned hi);
      return {1'($urandom_range(1)), 16'($urandom_range(hi))};
   endfunction

   // Offer one command and hold it until the transfer
   task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [SAMPLE_W-1:0] sample);
      sss_req_type cmd;
      int          gap;
      cmd.mode          = mode;
      cmd.random_sample = sample;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 7) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
      tracker.note_command(cmd);
   endtask

   task automatic tick_run(input int n);
      repeat (n) send_cmd(MODE_TICK, rand_sample());
   endtask

   // Mostly ticks while asleep; while awake, fall back asleep soon
   task automatic run_random(input int n);
      int unsigned         r;
      logic [MODE_W-1:0]   mode;
      repeat (n) begin
         r = $urandom_range(99);
         if (tracker.is_asleep())
            mode = (r < 90) ? MODE_TICK : (r < 94) ? MODE_WAKE :
                   (r < 97) ? MODE_UNUSED : MODE_SLEEP;
         else
            mode = (r < 60) ? MODE_SLEEP : (r < 75) ? MODE_TICK :
                   (r < 85) ? MODE_WAKE : MODE_UNUSED;
         send_cmd(mode, rand_sample());
      end
   endtask

   // Drop valid and wait until every report has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] nb, nmin, nshr, rb, rg, rmax,
                               theta, thr);
      logic [CSR_DATA_W-1:0] img [8];
      img[CSR_NREM_BASE]   = nb;
      img[CSR_NREM_MIN]    = nmin;
      img[CSR_NREM_SHRINK] = nshr;
      img[CSR_REM_BASE]    = rb;
      img[CSR_REM_GROW]    = rg;
      img[CSR_REM_MAX]     = rmax;
      img[CSR_THETA_INC]   = theta;
      img[CSR_PGO_THR]     = thr;
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(i);
         csr_wdata <= img[i];
         @(posedge clock);
         tracker.set_reg(CSR_ADDR_W'(i), img[i]);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: commands while awake, repeated sleep, unused mode, wake
      send_cmd(MODE_TICK, 16'h1234);
      send_cmd(MODE_WAKE, 16'h0000);
      send_cmd(MODE_UNUSED, 16'hFFFF);
      send_cmd(MODE_SLEEP, 16'h0000);
      send_cmd(MODE_SLEEP, 16'hFFFF);
      send_cmd(MODE_TICK, 16'h0000);
      send_cmd(MODE_TICK, 16'hFFFF);
      send_cmd(MODE_UNUSED, 16'h5555);
      send_cmd(MODE_WAKE, 16'hAAAA);
      send_cmd(MODE_TICK, 16'h0001);
      send_cmd(MODE_SLEEP, 16'h8000);
      run_random(60);

      // Short stages, zero-length first REM, PGO always fires, phase wraps each tick
      settle();
      program_regs(3, 1, 2, 0, 2, 3, 16'hFFFF, 17'h10000);
      send_cmd(MODE_WAKE, 16'h0000);
      send_cmd(MODE_SLEEP, 16'h0000);
      for (int k = 0; k < 12; k++) send_cmd(MODE_TICK, k[0] ? 16'hFFFF : 16'h0000);
      hold_asks <= hold_asks + 1;
      run_random(120);

      // Zero-length stages, PGO never fires; no idling on either side
      settle();
      program_regs(0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 17'h00000);
      calm <= 1'b1;
      run_random(80);
      calm <= 1'b0;

      // Random small length settings, full-range phase step and PGO threshold
      repeat (3) begin
         settle();
         program_regs(rand_len(12), rand_len(6), rand_len(4), rand_len(6), rand_len(3),
                      rand_len(10), rand_len(65535), CSR_DATA_W'($urandom_range(65536)));
         hold_asks <= hold_asks + 1;
         run_random(100);
      end

      // Short first NREM, REM capped below an overflowing base
      settle();
      program_regs(20, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 1, 17'h08000);
      send_cmd(MODE_WAKE, 16'h0000);
      send_cmd(MODE_SLEEP, 16'h0000);
      tick_run(40);
      run_random(40);

      // Large shrink and growth: floor and cap take over
      settle();
      program_regs(100, 3, 16'hFFFF, 1, 16'hFFFF, 9, rand_len(65535),
                   CSR_DATA_W'($urandom_range(65536)));
      tick_run(40);
      run_random(60);

      settle();
      repeat (5) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
design/sss_pkg.sv
design/sleep_stage_sequencer.sv
tb/tb_sleep_stage_sequencer.sv
